// File: hw/rtl/mtbr_pkg.sv
// Shared types and constants for the bounded MT19937 generator.
// No dependencies; imported by mtbr_front, mtbr_engine, the top level and the testbench.

package mtbr_pkg;

    // generator geometry
    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int POS_W         = $clog2(STATE_WORDS);

    // recurrence and tempering constants
    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
    localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
    localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;

    // opcodes on the input port
    typedef enum logic [1:0] {
        OP_RAW     = 2'd0,
        OP_BOUNDED = 2'd1,
        OP_SEED    = 2'd2
    } opcode_t;

    // classified command kinds
    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_BOUNDED,
        KIND_SEED,
        KIND_FIXED
    } kind_t;

    // command handed from the front end to the engine
    typedef struct packed {
        kind_t       kind;
        logic [31:0] operand;
        logic [31:0] mask;
        logic        err;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        logic [31:0] word;
        logic        err;
    } result_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(result_t);

endpackage

// File: hw/rtl/mtbr_front.sv
// Front end: decodes the opcode, flags a zero bound and builds the draw mask.
// Depends on mtbr_pkg.

module mtbr_front
    import mtbr_pkg::*;
(
    input  logic [1:0]  opcode,
    input  logic [31:0] operand_value,
    output cmd_t        cmd
);

    // smallest all-ones mask that covers the bound
    function automatic logic [31:0] smear(input logic [31:0] v);
        logic [31:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

    // classify the incoming transaction
    always_comb
    begin
        cmd.kind    = KIND_FIXED;
        cmd.operand = operand_value;
        cmd.mask    = '1;
        cmd.err     = 1'b0;
        unique case (opcode_t'(opcode))
            OP_RAW:
            begin
                cmd.kind = KIND_RAW;
            end
            OP_BOUNDED:
            begin
                if (operand_value == 32'd0)
                begin
                    cmd.kind = KIND_FIXED;
                    cmd.err  = 1'b1;
                end
                else
                begin
                    cmd.kind = KIND_BOUNDED;
                    cmd.mask = smear(operand_value);
                end
            end
            OP_SEED:
            begin
                cmd.kind = KIND_SEED;
            end
            default:
            begin
                cmd.kind = KIND_FIXED;
            end
        endcase
    end

endmodule

// File: hw/rtl/mtbr_queue.sv
// Small first-in first-out queue of flat words.
// Depends on nothing; used for the command and result queues.

module mtbr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr_fire;
    logic             rd_fire;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // storage slots
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({wr_fire, rd_fire})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/mtbr_engine.sv
// Back end: holds the 624-word state memory and runs seeding, twisting,
// tempering and bounded rejection. Depends on mtbr_pkg.

module mtbr_engine
    import mtbr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    res_not_full,
    output logic    res_push,
    output result_t res_data,
    output logic    clearing
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEED_MUL,
        S_SEED_ADD,
        S_DRAW,
        S_TW_PRIME,
        S_TW_LOAD,
        S_TW_READ,
        S_TW_CALC,
        S_FETCH,
        S_TEMPER
    } state_t;

    state_t           state_reg;
    logic [POS_W-1:0] idx_reg;
    logic [POS_W-1:0] pos_reg;
    cmd_t             cmd_reg;
    logic [31:0]      prev_reg;
    logic [31:0]      prod_reg;
    logic [31:0]      cur_reg;
    logic             res_push_reg;
    result_t          res_data_reg;

    logic [31:0]      words_mem [STATE_WORDS];
    logic [31:0]      rdata_a_reg;
    logic [31:0]      rdata_b_reg;

    logic             mem_we;
    logic [POS_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [POS_W-1:0] addr_a;
    logic [POS_W-1:0] addr_b;

    logic             idx_last;
    logic [POS_W-1:0] idx_inc;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W:0]   mid_sum;
    logic [POS_W-1:0] mid_idx;
    logic [31:0]      twist_y;
    logic [31:0]      twist_word;
    logic [31:0]      seed_sum;
    logic [31:0]      drawn;
    logic             draw_ok;
    logic             start;

    // output tempering of one state word
    function automatic logic [31:0] temper(input logic [31:0] v);
        logic [31:0] t;
        t = v;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    // index arithmetic, all modulo the state size
    assign idx_last = (idx_reg == POS_W'(STATE_WORDS - 1));
    assign idx_inc  = idx_last ? '0 : idx_reg + 1'b1;
    assign pos_inc  = (pos_reg == POS_W'(STATE_WORDS - 1)) ? '0 : pos_reg + 1'b1;
    assign mid_sum  = {1'b0, idx_reg} + (POS_W + 1)'(MIDDLE_OFFSET);
    assign mid_idx  = (mid_sum >= (POS_W + 1)'(STATE_WORDS))
                    ? POS_W'(mid_sum - (POS_W + 1)'(STATE_WORDS))
                    : mid_sum[POS_W-1:0];

    // twist of one word from the current, next and middle words
    assign twist_y    = (cur_reg & UPPER_BIT) | (rdata_a_reg & LOWER_BITS);
    assign twist_word = rdata_b_reg ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : 32'd0);

    // seeding recurrence, second half
    assign seed_sum = prod_reg + 32'(idx_reg);

    // tempered draw and rejection test
    assign drawn   = temper(rdata_a_reg) & cmd_reg.mask;
    assign draw_ok = (cmd_reg.kind != KIND_BOUNDED) || (drawn < cmd_reg.operand);

    // take a command only when the result queue is sure to have a slot
    assign start    = (state_reg == S_IDLE) && cmd_valid && res_not_full && !res_push_reg;
    assign cmd_pop  = start;
    assign res_push = res_push_reg;
    assign res_data = res_data_reg;
    assign clearing = (state_reg == S_CLEAR);

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = 32'd0;
        addr_a    = pos_reg;
        addr_b    = mid_idx;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                mem_we    = start && (cmd.kind == KIND_SEED);
                mem_waddr = '0;
                mem_wdata = cmd.operand;
            end
            S_SEED_ADD:
            begin
                mem_we    = 1'b1;
                mem_wdata = seed_sum;
            end
            S_TW_PRIME:
            begin
                addr_a = '0;
            end
            S_TW_READ:
            begin
                addr_a = idx_inc;
            end
            S_TW_CALC:
            begin
                mem_we    = 1'b1;
                mem_wdata = twist_word;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // state word memory, registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            words_mem[mem_waddr] <= mem_wdata;
        end
        rdata_a_reg <= words_mem[addr_a];
        rdata_b_reg <= words_mem[addr_b];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            pos_reg      <= '0;
            res_push_reg <= 1'b0;
        end
        else
        begin
            res_push_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_inc;
                    if (idx_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        unique case (cmd.kind)
                            KIND_RAW, KIND_BOUNDED:
                            begin
                                state_reg <= S_DRAW;
                            end
                            KIND_SEED:
                            begin
                                prev_reg  <= cmd.operand;
                                idx_reg   <= POS_W'(1);
                                state_reg <= S_SEED_MUL;
                            end
                            KIND_FIXED:
                            begin
                                res_push_reg      <= 1'b1;
                                res_data_reg.word <= 32'd0;
                                res_data_reg.err  <= cmd.err;
                            end
                        endcase
                    end
                end
                S_SEED_MUL:
                begin
                    prod_reg  <= SEED_MULT * (prev_reg ^ (prev_reg >> 30));
                    state_reg <= S_SEED_ADD;
                end
                S_SEED_ADD:
                begin
                    prev_reg <= seed_sum;
                    if (idx_last)
                    begin
                        res_push_reg      <= 1'b1;
                        res_data_reg.word <= 32'd0;
                        res_data_reg.err  <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SEED_MUL;
                    end
                end
                S_DRAW:
                begin
                    // position zero regenerates the whole state first
                    state_reg <= (pos_reg == '0) ? S_TW_PRIME : S_TEMPER;
                end
                S_TW_PRIME:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_TW_LOAD;
                end
                S_TW_LOAD:
                begin
                    cur_reg   <= rdata_a_reg;
                    state_reg <= S_TW_READ;
                end
                S_TW_READ:
                begin
                    state_reg <= S_TW_CALC;
                end
                S_TW_CALC:
                begin
                    cur_reg <= rdata_a_reg;
                    if (idx_last)
                    begin
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_TW_READ;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_TEMPER;
                end
                S_TEMPER:
                begin
                    pos_reg <= pos_inc;
                    if (draw_ok)
                    begin
                        res_push_reg      <= 1'b1;
                        res_data_reg.word <= drawn;
                        res_data_reg.err  <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DRAW;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mersenne_twister_bounded_rng.sv
// Raw draw: the engine reads the state word, tempers it and registers the result;
// it takes no new command until that result has gone into the result queue.
// A draw at position zero first regenerates the whole state, twisting word by word.
// Bounded draw: read and temper attempts repeat until one falls below the bound; seed: word by word.
// Reset: a pass over all 624 words zeroes the state memory, full held high meanwhile.
// Top level; depends on mtbr_pkg, mtbr_front, mtbr_queue and mtbr_engine.

module mersenne_twister_bounded_rng
    import mtbr_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] operand_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] random_word,
    output logic        bound_error
);

    cmd_t             front_cmd;
    cmd_t             head_cmd;
    logic [CMD_W-1:0] head_cmd_bits;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             clearing;
    logic             res_full;
    logic             res_push;
    result_t          res_data;
    result_t          res_head;
    logic [RES_W-1:0] res_head_bits;

    // classify incoming transactions
    mtbr_front u_front (
        .opcode        (opcode),
        .operand_value (operand_value),
        .cmd           (front_cmd)
    );

    // command queue between front and engine
    mtbr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !clearing),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd_bits),
        .empty   (cmd_empty)
    );

    assign head_cmd = cmd_t'(head_cmd_bits);
    assign full     = cmd_full || clearing;

    // generator engine
    mtbr_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!cmd_empty),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .res_not_full (!res_full),
        .res_push     (res_push),
        .res_data     (res_data),
        .clearing     (clearing)
    );

    // result queue towards the consumer
    mtbr_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head_bits),
        .empty   (empty)
    );

    assign res_head    = result_t'(res_head_bits);
    assign random_word = res_head.word;
    assign bound_error = res_head.err;

endmodule

// File: hw/rtl/mtbr_checker.sv
// Port-level checks for the bounded MT19937 generator, bound to the top level.
// Depends on mersenne_twister_bounded_rng.

module mtbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] random_word,
    input logic        bound_error
);

    logic [7:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = push && !full;
    assign out_fire = pop && !empty;

    // transactions accepted but not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_fire) - 8'(out_fire);
        end
    end

    // clearing pass blocks input and nothing is waiting right after reset
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> full && empty)
        else $error("block not blocked and empty after reset");

    // a result is never offered without an outstanding transaction
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != 8'd0)
        else $error("result offered without a pending transaction");

    // the head result holds until taken
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(random_word) && $stable(bound_error))
        else $error("waiting result changed before pop");

    // an error result carries a zero word
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && bound_error |-> random_word == 32'd0)
        else $error("error result with non-zero word");

endmodule

bind mersenne_twister_bounded_rng mtbr_checker u_mtbr_checker (.*);

// File: dv/mersenne_twister_bounded_rng_test.sv
// Self-checking testbench for the bounded MT19937 generator: queue-style driver and monitor
// around mersenne_twister_bounded_rng, with an in-bench generator model predicting each result.
// Depends on mtbr_pkg and the block's RTL.
`timescale 1ns / 100ps

module mersenne_twister_bounded_rng_test;
    import mtbr_pkg::*;

    // one pending command for the driver
    typedef struct {
        opcode_t     op;
        logic [31:0] operand;
        int          gap;
        bit          drain;
    } gen_cmd_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic [1:0]  opcode        = OP_RAW;
    logic [31:0] operand_value = 32'd0;
    logic        empty;
    logic        pop           = 1'b0;
    logic [31:0] random_word;
    logic        bound_error;

    // generator model state
    bit [31:0]   gen_words [STATE_WORDS];
    int          gen_pos = 0;

    gen_cmd_t    pending_cmds [$];
    result_t     expected_results [$];

    // handshake bookkeeping shared between monitor, driver and consumer
    bit          took_cmd    = 1'b0;
    bit          took_result = 1'b0;
    bit          cmd_loaded  = 1'b0;
    gen_cmd_t    cur_cmd;
    int          cmd_gap     = 0;
    int          res_stall   = 0;
    bit          calm_rx     = 1'b0;
    int          mismatches  = 0;

    mersenne_twister_bounded_rng u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .operand_value (operand_value),
        .empty         (empty),
        .pop           (pop),
        .random_word   (random_word),
        .bound_error   (bound_error)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // twist the whole word store in place
    function automatic void regenerate_words();
        logic [31:0] y;
        logic [31:0] w;
        int          i;
        for (i = 0; i < STATE_WORDS; i++)
        begin
            y = (gen_words[i] & UPPER_BIT) | (gen_words[(i + 1) % STATE_WORDS] & LOWER_BITS);
            w = gen_words[(i + MIDDLE_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
                w = w ^ TWIST_XOR;
            gen_words[i] = w;
        end
    endfunction

    // standard initialisation recurrence; read position left alone
    function automatic void reseed_words(logic [31:0] seed);
        logic [31:0] prev;
        int          i;
        gen_words[0] = seed;
        for (i = 1; i < STATE_WORDS; i++)
        begin
            prev = gen_words[i - 1];
            gen_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
        end
    endfunction

    // one tempered draw, regenerating when the position wraps to zero
    function automatic logic [31:0] draw_word();
        logic [31:0] y;
        if (gen_pos >= STATE_WORDS)
            gen_pos = 0;
        if (gen_pos == 0)
            regenerate_words();
        y = gen_words[gen_pos];
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        gen_pos = (gen_pos + 1) % STATE_WORDS;
        return y;
    endfunction

    // rejection mask: next power of two, doubled on an exact power, minus one
    function automatic logic [31:0] bound_mask_of(logic [31:0] bound);
        logic [31:0] p;
        if (bound > UPPER_BIT)
            return 32'hffff_ffff;
        p = bound - 32'd1;
        p = p | (p >> 1);
        p = p | (p >> 2);
        p = p | (p >> 4);
        p = p | (p >> 8);
        p = p | (p >> 16);
        p = p + 32'd1;
        if (p == bound)
            p = p << 1;
        return p - 32'd1;
    endfunction

    // expected result of one command, advancing the model state
    function automatic result_t predict_result(logic [1:0] op, logic [31:0] val);
        result_t     res;
        logic [31:0] m;
        logic [31:0] r;
        res.word = 32'd0;
        res.err  = 1'b0;
        case (op)
            OP_RAW:
                res.word = draw_word();
            OP_BOUNDED:
                if (val == 32'd0)
                    res.err = 1'b1;
                else
                begin
                    m = bound_mask_of(val);
                    do
                        r = draw_word() & m;
                    while (r >= val);
                    res.word = r;
                end
            OP_SEED:
                reseed_words(val);
            default:
                res.word = 32'd0;
        endcase
        return res;
    endfunction

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d: %s", mismatches, msg);
    endtask

    // monitor: both handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        result_t exp_res;
        took_cmd    = push && !full;
        took_result = pop && !empty;
        if (took_result)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected transaction word %h err %b",
                                       random_word, bound_error));
            else
            begin
                exp_res = expected_results.pop_front();
                if (random_word !== exp_res.word || bound_error !== exp_res.err)
                    note_failure($sformatf("expected word %h err %b, got word %h err %b",
                                           exp_res.word, exp_res.err,
                                           random_word, bound_error));
            end
        end
        if (took_cmd)
            expected_results.push_back(predict_result(opcode, operand_value));
    end

    // command driver
    always @(negedge clk)
    begin
        logic push_nxt;
        if (rst_n)
        begin
            push_nxt = push;
            if (push && took_cmd)
            begin
                push_nxt   = 1'b0;
                cmd_loaded = 1'b0;
            end
            if (!cmd_loaded && pending_cmds.size() != 0)
            begin
                cur_cmd    = pending_cmds.pop_front();
                cmd_loaded = 1'b1;
                cmd_gap    = cur_cmd.gap;
            end
            if (cmd_loaded && !push_nxt)
            begin
                if (cmd_gap != 0)
                    cmd_gap--;
                else if (!cur_cmd.drain || expected_results.size() == 0)
                begin
                    push_nxt      = 1'b1;
                    opcode        <= cur_cmd.op;
                    operand_value <= cur_cmd.operand;
                end
            end
            push <= push_nxt;
        end
    end

    // result consumer with random stalls and calm stretches
    always @(negedge clk)
    begin
        logic pop_nxt;
        if (rst_n)
        begin
            pop_nxt = pop;
            if (pop && took_result)
            begin
                pop_nxt   = 1'b0;
                res_stall = calm_rx ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 39) == 0)
                    calm_rx = !calm_rx;
            end
            if (!pop_nxt)
            begin
                if (res_stall != 0)
                    res_stall--;
                else
                    pop_nxt = 1'b1;
            end
            pop <= pop_nxt;
        end
    end

    task automatic queue_cmd(opcode_t op, logic [31:0] val, int gap, bit drain);
        gen_cmd_t c;
        c.op      = op;
        c.operand = val;
        c.gap     = gap;
        c.drain   = drain;
        pending_cmds.push_back(c);
    endtask

    // random bound: fixed edge values or a random bit width, never zero
    function automatic logic [31:0] pick_bound();
        logic [31:0] b;
        int          k;
        case ($urandom_range(0, 19))
            0:       b = 32'h8000_0000;
            1:       b = 32'hffff_ffff;
            2:       b = 32'h8000_0000 + $urandom_range(1, 1000);
            3:       b = 32'd1;
            default:
            begin
                k = $urandom_range(1, 32);
                b = $urandom;
                if (k < 32)
                    b = b & ((32'd1 << k) - 32'd1);
            end
        endcase
        if (b == 32'd0)
            b = 32'd1;
        return b;
    endfunction

    // stimulus and end of run
    initial
    begin
        bit calm_tx;
        int n;
        int gap;
        int sel;

        // unseeded draws, extremes of the bound, seeds at both ends of the range
        queue_cmd(OP_RAW,     32'h0000_0000, 0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd1,         0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd0,         0, 1'b0);
        queue_cmd(OP_RAW,     32'hffff_ffff, 0, 1'b0);
        queue_cmd(OP_SEED,    32'd5489,      0, 1'b0);
        queue_cmd(OP_RAW,     32'hffff_ffff, 0, 1'b0);
        queue_cmd(OP_RAW,     32'h0000_0000, 1, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd1,         0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd2,         0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd3,         2, 1'b0);
        queue_cmd(OP_BOUNDED, 32'h4000_0000, 0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'h7fff_ffff, 0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'h8000_0000, 0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'h8000_0001, 0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'hffff_ffff, 3, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd0,         0, 1'b0);
        queue_cmd(OP_SEED,    32'h0000_0000, 0, 1'b0);
        queue_cmd(OP_RAW,     32'h5555_5555, 0, 1'b0);
        queue_cmd(OP_SEED,    32'hffff_ffff, 0, 1'b0);
        queue_cmd(OP_RAW,     32'haaaa_aaaa, 0, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd6,         0, 1'b0);
        queue_cmd(OP_SEED,    32'h8000_0000, 4, 1'b0);
        queue_cmd(OP_BOUNDED, 32'd100,       0, 1'b0);

        // random commands: mostly draws, occasional reseeds and zero bounds
        calm_tx = 1'b0;
        for (n = 0; n < 1950; n++)
        begin
            if ($urandom_range(0, 49) == 0)
                calm_tx = !calm_tx;
            gap = calm_tx ? 0 : $urandom_range(0, 6);
            sel = $urandom_range(0, 99);
            if (sel < 45)
                queue_cmd(OP_RAW, $urandom, gap, n % 600 == 10);
            else if (sel < 92)
                queue_cmd(OP_BOUNDED, pick_bound(), gap, n % 600 == 10);
            else if (sel < 96)
                queue_cmd(OP_SEED, $urandom, gap, n % 600 == 10);
            else
                queue_cmd(OP_BOUNDED, 32'd0, gap, n % 600 == 10);
        end

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain everything, then let the block settle
        while (pending_cmds.size() != 0 || cmd_loaded)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
